### hdl/dual_ultrasonic_range_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// dual ultrasonic range sequencer assertion macros
// checks that hold under reset gating on the block clock
// ----------------------------------------------------------------------------
`ifndef DUAL_ULTRASONIC_RANGE_SEQUENCER_CORE_DEFINES_SVH
`define DUAL_ULTRASONIC_RANGE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define DURS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DURS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/durs_pkg.sv
// ----------------------------------------------------------------------------
// durs_pkg
// shared types, register indexes and the tick to millimetre conversion
// ----------------------------------------------------------------------------
package durs_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int DIST_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    typedef logic [DIST_W-1:0]       distance_t;
    typedef logic [COUNTER_BITS-1:0] tick_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_CEILING = 2'd3;

    localparam logic [7:0]        TRIGGER_TICKS_RST    = 8'd10;
    localparam logic [15:0]       TIMEOUT_TICKS_RST    = 16'd30000;
    localparam logic [3:0]        GROUP_SIZE_RST       = 4'd10;
    localparam logic [DIST_W-1:0] DISTANCE_CEILING_RST = 16'd4001;

    localparam tick_t     TICK_MAX = '1;
    localparam distance_t DIST_MAX = '1;

    // ticks*17/100: product of ticks and 17, then a reciprocal multiply for /100
    localparam int PROD_W    = COUNTER_BITS + 5;
    localparam int DIV_SHIFT = PROD_W + 7;
    localparam int RECIP_W   = PROD_W + 1;
    localparam int BIG_W     = PROD_W + RECIP_W;
    localparam int QUO_W     = PROD_W - 6;
    localparam int QEXT_W    = (QUO_W > DIST_W) ? QUO_W : DIST_W;
    localparam logic [RECIP_W-1:0] DIV100_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);

    function automatic distance_t to_mm(input tick_t ticks);
        logic [PROD_W-1:0] prod;
        logic [BIG_W-1:0]  big;
        logic [QUO_W-1:0]  quo;
        logic [QEXT_W-1:0] quo_ext;
        prod    = (PROD_W'(ticks) << 4) + PROD_W'(ticks);
        big     = BIG_W'(prod) * BIG_W'(DIV100_RECIP);
        quo     = QUO_W'(big >> DIV_SHIFT);
        quo_ext = QEXT_W'(quo);
        if (quo_ext > QEXT_W'(DIST_MAX))
        begin
            return DIST_MAX;
        end
        return quo_ext[DIST_W-1:0];
    endfunction

endpackage

### hdl/dual_ultrasonic_range_sequencer_core.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_range_sequencer_core
// two-sensor ultrasonic ranging sequencer with group minimum reporting
// ----------------------------------------------------------------------------
// Each input word is one 1 us timer tick with both echo levels; each accepted
// word gives exactly one result word with both trigger levels and, when a
// group of measurements is complete, its minimum distance in millimetres.
// The block takes one word per clock: the next sequencer state is computed
// combinationally from the state registers and the echo levels, and the result
// lands in an output register, so a new tick is accepted every cycle unless
// that register holds a word the sink has not taken. The conversion
// ticks*17/100 is a shift-add and one constant reciprocal multiply in the
// update path. Configuration writes take effect on the next tick.
// ----------------------------------------------------------------------------
`include "dual_ultrasonic_range_sequencer_core_defines.svh"

module dual_ultrasonic_range_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [durs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [durs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                echo_left,
    input  logic                                echo_right,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                trigger_left,
    output logic                                trigger_right,
    output logic                                left_ready,
    output durs_pkg::distance_t                 left_distance,
    output logic                                right_ready,
    output durs_pkg::distance_t                 right_distance
);
    import durs_pkg::*;

    localparam logic [3:0] PH_L_START = 4'd0;
    localparam logic [3:0] PH_L_TRIG  = 4'd1;
    localparam logic [3:0] PH_L_WAIT  = 4'd2;
    localparam logic [3:0] PH_L_ECHO  = 4'd3;
    localparam logic [3:0] PH_R_START = 4'd4;
    localparam logic [3:0] PH_R_TRIG  = 4'd5;
    localparam logic [3:0] PH_R_WAIT  = 4'd6;
    localparam logic [3:0] PH_R_ECHO  = 4'd7;
    localparam logic [3:0] PH_REST    = 4'd8;

    localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    // configuration
    logic [7:0]  trigger_ticks_reg;
    logic [15:0] timeout_ticks_reg;
    logic [3:0]  group_size_reg;
    distance_t   ceiling_reg;

    // sequencer state
    logic [3:0]  phase_reg, phase_next;
    tick_t       tick_reg, tick_next;
    distance_t   min_left_reg, min_left_next;
    distance_t   min_right_reg, min_right_next;
    logic [3:0]  count_left_reg, count_left_next;
    logic [3:0]  count_right_reg, count_right_next;
    logic        trig_l_reg, trig_l_next;
    logic        trig_r_reg, trig_r_next;

    // result word
    logic        out_valid_reg;
    logic        res_trig_l_reg, res_trig_r_reg;
    logic        res_left_ready_reg, res_right_ready_reg;
    distance_t   res_left_dist_reg, res_right_dist_reg;

    logic        in_fire;
    logic [3:0]  group_eff;
    logic        left_report, right_report;
    distance_t   left_dist_next, right_dist_next;
    tick_t       tick_act;
    logic [3:0]  phase_act;
    distance_t   mm_left, mm_right;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign group_eff = (group_size_reg == 4'd0) ? 4'd1 : group_size_reg;
    assign mm_left   = to_mm(tick_reg);
    assign mm_right  = to_mm(tick_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            group_size_reg    <= GROUP_SIZE_RST;
            ceiling_reg       <= DISTANCE_CEILING_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TRIGGER_TICKS:    trigger_ticks_reg <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS:    timeout_ticks_reg <= cfg_data[15:0];
                CFG_GROUP_SIZE:       group_size_reg    <= cfg_data[3:0];
                CFG_DISTANCE_CEILING: ceiling_reg       <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_act        = phase_reg;
        tick_act         = tick_reg;
        min_left_next    = min_left_reg;
        min_right_next   = min_right_reg;
        count_left_next  = count_left_reg;
        count_right_next = count_right_reg;
        trig_l_next      = trig_l_reg;
        trig_r_next      = trig_r_reg;
        left_report      = 1'b0;
        right_report     = 1'b0;
        left_dist_next   = '0;
        right_dist_next  = '0;

        case (phase_reg)
            PH_L_START:
            begin
                tick_act    = '0;
                trig_l_next = 1'b1;
                phase_act   = PH_L_TRIG;
            end
            PH_L_TRIG:
            begin
                if (tick_reg >= COUNTER_BITS'(trigger_ticks_reg))
                begin
                    trig_l_next = 1'b0;
                    phase_act   = PH_L_WAIT;
                end
            end
            PH_L_WAIT:
            begin
                if (echo_left)
                begin
                    tick_act  = '0;
                    phase_act = PH_L_ECHO;
                end
            end
            PH_L_ECHO:
            begin
                if (!echo_left)
                begin
                    if (mm_left < min_left_reg)
                    begin
                        min_left_next = mm_left;
                    end
                    count_left_next = count_left_reg + 4'd1;
                    phase_act       = PH_R_START;
                end
            end
            PH_R_START:
            begin
                tick_act    = '0;
                trig_r_next = 1'b1;
                phase_act   = PH_R_TRIG;
            end
            PH_R_TRIG:
            begin
                if (tick_reg >= COUNTER_BITS'(trigger_ticks_reg))
                begin
                    trig_r_next = 1'b0;
                    phase_act   = PH_R_WAIT;
                end
            end
            PH_R_WAIT:
            begin
                if (echo_right)
                begin
                    tick_act  = '0;
                    phase_act = PH_R_ECHO;
                end
            end
            PH_R_ECHO:
            begin
                if (!echo_right)
                begin
                    if (mm_right < min_right_reg)
                    begin
                        min_right_next = mm_right;
                    end
                    count_right_next = count_right_reg + 4'd1;
                    phase_act        = PH_REST;
                end
            end
            default: ;
        endcase

        // timeout restarts the left side (or the whole cycle) or the right side
        phase_next = phase_act;
        if (CMP_W'(tick_act) > CMP_W'(timeout_ticks_reg))
        begin
            phase_next = (phase_act < PH_R_START || phase_act == PH_REST) ?
                         PH_L_START : PH_R_START;
        end

        if (count_left_next >= group_eff)
        begin
            left_report     = 1'b1;
            left_dist_next  = min_left_next;
            count_left_next = 4'd0;
            min_left_next   = ceiling_reg;
        end
        if (count_right_next >= group_eff)
        begin
            right_report     = 1'b1;
            right_dist_next  = min_right_next;
            count_right_next = 4'd0;
            min_right_next   = ceiling_reg;
        end

        tick_next = (tick_act < TICK_MAX) ? tick_act + COUNTER_BITS'(1) : tick_act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_L_START;
            tick_reg        <= '0;
            min_left_reg    <= DISTANCE_CEILING_RST;
            min_right_reg   <= DISTANCE_CEILING_RST;
            count_left_reg  <= 4'd0;
            count_right_reg <= 4'd0;
            trig_l_reg      <= 1'b0;
            trig_r_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            min_left_reg    <= min_left_next;
            min_right_reg   <= min_right_next;
            count_left_reg  <= count_left_next;
            count_right_reg <= count_right_next;
            trig_l_reg      <= trig_l_next;
            trig_r_reg      <= trig_r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_trig_l_reg      <= trig_l_next;
            res_trig_r_reg      <= trig_r_next;
            res_left_ready_reg  <= left_report;
            res_right_ready_reg <= right_report;
            res_left_dist_reg   <= left_dist_next;
            res_right_dist_reg  <= right_dist_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_left   = res_trig_l_reg;
    assign trigger_right  = res_trig_r_reg;
    assign left_ready     = res_left_ready_reg;
    assign right_ready    = res_right_ready_reg;
    assign left_distance  = res_left_dist_reg;
    assign right_distance = res_right_dist_reg;

    `DURS_ASSERT_NEXT(a_left_start_raises_trigger, clk, rst_n,
        in_fire && phase_reg == PH_L_START, trig_l_reg,
        "left trigger not raised at start of left phase")
    `DURS_ASSERT_NEXT(a_report_clears_count, clk, rst_n,
        in_fire && left_report, count_left_reg == 4'd0 && min_left_reg == $past(ceiling_reg),
        "left group not restarted after report")
    `DURS_ASSERT_NEXT(a_idle_holds_state, clk, rst_n,
        !in_fire, $stable(phase_reg) && $stable(tick_reg) && $stable(count_right_reg),
        "sequencer state moved without an accepted word")
    `DURS_ASSERT_NOW(a_quiet_side_zero, clk, rst_n,
        out_valid_reg && !res_right_ready_reg, res_right_dist_reg == '0,
        "right distance nonzero without a report")

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timer ticks with echo levels into the dual range sequencer and checks
// every result word against a cycle-free model of the sequencer, first from a
// short stimulus table, then from echo pulses shaped to the predicted phase.
// ----------------------------------------------------------------------------
module testbench;

    import durs_pkg::*;

    localparam int STUCK_LIMIT = 3000;
    localparam int LONG_HOLD   = 200;
    localparam int PRINT_CAP   = 100;

    typedef enum logic [3:0] {
        PH_START_L, PH_PULSE_L, PH_WAIT_L, PH_ECHO_L,
        PH_START_R, PH_PULSE_R, PH_WAIT_R, PH_ECHO_R, PH_REST
    } sweep_phase_t;

    typedef struct packed {
        logic      trig_l;
        logic      trig_r;
        logic      left_rdy;
        distance_t left_mm;
        logic      right_rdy;
        distance_t right_mm;
    } ranging_word_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic                    el;
        logic                    er;
        logic                    typed;
        ranging_word_t           word;
    } dir_row_t;

    typedef struct packed {
        logic [7:0]  trig;
        logic [15:0] timeout;
        logic [3:0]  grp;
        logic [15:0] ceil;
        int          snd_pct;
        int          rcv_pct;
        int          items;
        logic        long_hold;
        logic        regroup;
    } sweep_setting_t;

    localparam ranging_word_t NO_WORD = '0;
    localparam ranging_word_t W_TRIG_L = '{1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0};
    localparam ranging_word_t W_LEFT_0 = '{1'b0, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0};
    localparam ranging_word_t W_RIGHT_0 = '{1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 16'd0};

    localparam dir_row_t DIR_ROWS [24] = '{
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b1, W_TRIG_L},
        '{ROW_CFG,  CFG_TRIGGER_TICKS,    16'd1,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_GROUP_SIZE,       16'd1,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_DISTANCE_CEILING, 16'hFFFF,  1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b1, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b1, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b1, W_LEFT_0},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b1, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b1, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b1, 1'b1, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b1, 1'b0, 1'b1, W_RIGHT_0},
        '{ROW_CFG,  CFG_TIMEOUT_TICKS,    16'd1,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b1, 1'b1, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b0, NO_WORD},
        // trigger pulse longer than the timeout: restart with trigger still high
        '{ROW_CFG,  CFG_TRIGGER_TICKS,    16'd255,   1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b1, W_TRIG_L},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_GROUP_SIZE,       16'd0,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_TRIGGER_TICKS,    16'd1,     1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_CFG,  CFG_TIMEOUT_TICKS,    16'd65534, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_TRIGGER_TICKS,    16'd0,     1'b0, 1'b0, 1'b0, NO_WORD}
    };

    localparam sweep_setting_t SWEEPS [7] = '{
        '{8'd1,   16'd40,  4'd1,  16'd4001,  0,  0,  120, 1'b0, 1'b0},
        '{8'd4,   16'd60,  4'd3,  16'd65535, 70, 0,  120, 1'b0, 1'b0},
        '{8'd1,   16'd1,   4'd2,  16'd0,     0,  70, 120, 1'b1, 1'b0},
        '{8'd255, 16'd300, 4'd1,  16'd500,   28, 28, 400, 1'b0, 1'b0},
        '{8'd2,   16'd100, 4'd15, 16'd1234,  28, 28, 200, 1'b0, 1'b1},
        '{8'd3,   16'd30,  4'd0,  16'd65535, 70, 70, 120, 1'b0, 1'b0},
        '{8'd1,   16'd50,  4'd4,  16'd2000,  0,  0,  100, 1'b0, 1'b0}
    };

    bit                     clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   echo_left;
    logic                   echo_right;
    logic                   out_valid;
    logic                   out_ready;
    logic                   trigger_left;
    logic                   trigger_right;
    logic                   left_ready;
    distance_t              left_distance;
    logic                   right_ready;
    distance_t              right_distance;

    dual_ultrasonic_range_sequencer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .echo_left      (echo_left),
        .echo_right     (echo_right),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trigger_left   (trigger_left),
        .trigger_right  (trigger_right),
        .left_ready     (left_ready),
        .left_distance  (left_distance),
        .right_ready    (right_ready),
        .right_distance (right_distance)
    );

    // sequencer model state and its copy of the registers
    logic [7:0]     trig_ticks_cfg = TRIGGER_TICKS_RST;
    logic [15:0]    timeout_cfg    = TIMEOUT_TICKS_RST;
    logic [3:0]     group_cfg      = GROUP_SIZE_RST;
    distance_t      ceiling_cfg    = DISTANCE_CEILING_RST;
    sweep_phase_t   ph             = PH_START_L;
    tick_t          tick_cnt       = '0;
    distance_t      min_l          = DISTANCE_CEILING_RST;
    distance_t      min_r          = DISTANCE_CEILING_RST;
    logic [3:0]     cnt_l          = '0;
    logic [3:0]     cnt_r          = '0;
    logic           trig_l         = 1'b0;
    logic           trig_r         = 1'b0;

    ranging_word_t  pending_ranges [$];
    logic           cur_typed;
    ranging_word_t  cur_word;
    int             mismatches;
    int             stuck_cycles;
    int             snd_idle_pct;
    int             rcv_stall_pct;
    bit             hold_request;
    int             hold_left;
    int unsigned    echo_left_len;
    int unsigned    echo_right_len;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic distance_t mm_from_ticks(input tick_t t);
        int unsigned mm;
        mm = (32'(t) * 17) / 100;
        return (mm > 32'hFFFF) ? DIST_MAX : distance_t'(mm);
    endfunction

    // one timer tick through the sequencer model
    function automatic ranging_word_t advance_ranging(input logic el, input logic er);
        ranging_word_t w;
        logic [3:0]    gsz;
        distance_t     d;
        w   = '0;
        gsz = (group_cfg == 4'd0) ? 4'd1 : group_cfg;
        case (ph)
            PH_START_L:
            begin
                tick_cnt = '0;
                trig_l   = 1'b1;
                ph       = PH_PULSE_L;
            end
            PH_PULSE_L:
            begin
                if (tick_cnt >= tick_t'(trig_ticks_cfg))
                begin
                    trig_l = 1'b0;
                    ph     = PH_WAIT_L;
                end
            end
            PH_WAIT_L:
            begin
                if (el)
                begin
                    tick_cnt = '0;
                    ph       = PH_ECHO_L;
                end
            end
            PH_ECHO_L:
            begin
                if (!el)
                begin
                    d = mm_from_ticks(tick_cnt);
                    if (d < min_l)
                    begin
                        min_l = d;
                    end
                    cnt_l = cnt_l + 4'd1;
                    ph    = PH_START_R;
                end
            end
            PH_START_R:
            begin
                tick_cnt = '0;
                trig_r   = 1'b1;
                ph       = PH_PULSE_R;
            end
            PH_PULSE_R:
            begin
                if (tick_cnt >= tick_t'(trig_ticks_cfg))
                begin
                    trig_r = 1'b0;
                    ph     = PH_WAIT_R;
                end
            end
            PH_WAIT_R:
            begin
                if (er)
                begin
                    tick_cnt = '0;
                    ph       = PH_ECHO_R;
                end
            end
            PH_ECHO_R:
            begin
                if (!er)
                begin
                    d = mm_from_ticks(tick_cnt);
                    if (d < min_r)
                    begin
                        min_r = d;
                    end
                    cnt_r = cnt_r + 4'd1;
                    ph    = PH_REST;
                end
            end
            default:
            begin
            end
        endcase

        if (tick_cnt > tick_t'(timeout_cfg))
        begin
            ph = (ph < PH_START_R || ph == PH_REST) ? PH_START_L : PH_START_R;
        end

        if (cnt_l >= gsz)
        begin
            w.left_rdy = 1'b1;
            w.left_mm  = min_l;
            cnt_l      = '0;
            min_l      = ceiling_cfg;
        end
        if (cnt_r >= gsz)
        begin
            w.right_rdy = 1'b1;
            w.right_mm  = min_r;
            cnt_r       = '0;
            min_r       = ceiling_cfg;
        end

        if (tick_cnt != TICK_MAX)
        begin
            tick_cnt = tick_cnt + 1'b1;
        end
        w.trig_l = trig_l;
        w.trig_r = trig_r;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("%0t  %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic compare_word(input ranging_word_t got, input ranging_word_t want);
        if (got.trig_l !== want.trig_l)
            report_mismatch("trigger_left", got.trig_l, want.trig_l);
        if (got.trig_r !== want.trig_r)
            report_mismatch("trigger_right", got.trig_r, want.trig_r);
        if (got.left_rdy !== want.left_rdy)
            report_mismatch("left_ready", got.left_rdy, want.left_rdy);
        if (got.left_mm !== want.left_mm)
            report_mismatch("left_distance", got.left_mm, want.left_mm);
        if (got.right_rdy !== want.right_rdy)
            report_mismatch("right_ready", got.right_rdy, want.right_rdy);
        if (got.right_mm !== want.right_mm)
            report_mismatch("right_distance", got.right_mm, want.right_mm);
    endtask

    // accepted ticks feed the model, accepted words are checked in order
    always @(posedge clk)
    begin
        ranging_word_t want;
        ranging_word_t got;
        bit            moved;
        moved = 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            want = advance_ranging(echo_left, echo_right);
            if (cur_typed)
            begin
                want = cur_word;
            end
            pending_ranges.push_back(want);
            moved = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            moved = 1'b1;
            got   = '{trigger_left, trigger_right, left_ready, left_distance,
                      right_ready, right_distance};
            if (pending_ranges.size() == 0)
            begin
                report_mismatch("word with nothing pending", got.left_mm, 0);
            end
            else
            begin
                want = pending_ranges.pop_front();
                compare_word(got, want);
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sink side: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready = ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    task automatic send_tick(input logic el, input logic er, input logic typed,
                             input ranging_word_t word);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        echo_left  = el;
        echo_right = er;
        cur_typed  = typed;
        cur_word   = word;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_ranges.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            CFG_TRIGGER_TICKS:    trig_ticks_cfg = data[7:0];
            CFG_TIMEOUT_TICKS:    timeout_cfg    = data;
            CFG_GROUP_SIZE:       group_cfg      = data[3:0];
            CFG_DISTANCE_CEILING: ceiling_cfg    = data;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic int unsigned pick_echo_len();
        int unsigned r;
        int unsigned top;
        r   = $urandom_range(0, 9);
        top = (timeout_cfg > 16'd995) ? 1000 : int'(timeout_cfg) + 5;
        if (r < 6)
            return $urandom_range(0, 25);
        else if (r < 9)
            return $urandom_range(0, 200);
        return $urandom_range(0, top);
    endfunction

    // echo levels that answer the trigger the model says is pending
    task automatic shape_echo(output logic el, output logic er);
        el = 1'b0;
        er = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            el = 1'($urandom_range(0, 1));
            er = 1'($urandom_range(0, 1));
        end
        else
        begin
            case (ph)
                PH_WAIT_L:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        el            = 1'b1;
                        echo_left_len = pick_echo_len();
                    end
                end
                PH_ECHO_L:
                begin
                    if (echo_left_len != 0)
                    begin
                        el = 1'b1;
                        echo_left_len--;
                    end
                end
                PH_WAIT_R:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        er             = 1'b1;
                        echo_right_len = pick_echo_len();
                    end
                end
                PH_ECHO_R:
                begin
                    if (echo_right_len != 0)
                    begin
                        er = 1'b1;
                        echo_right_len--;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    initial
    begin
        logic el;
        logic er;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_TRIGGER_TICKS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        echo_left      = 1'b0;
        echo_right     = 1'b0;
        out_ready      = 1'b0;
        cur_typed      = 1'b0;
        cur_word       = NO_WORD;
        mismatches     = 0;
        stuck_cycles   = 0;
        snd_idle_pct   = 0;
        rcv_stall_pct  = 0;
        hold_request   = 1'b0;
        hold_left      = 0;
        echo_left_len  = 0;
        echo_right_len = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end
            else
            begin
                send_tick(DIR_ROWS[i].el, DIR_ROWS[i].er, DIR_ROWS[i].typed,
                          DIR_ROWS[i].word);
            end
        end

        foreach (SWEEPS[s])
        begin
            wait_drained();
            snd_idle_pct  = SWEEPS[s].snd_pct;
            rcv_stall_pct = SWEEPS[s].rcv_pct;
            write_reg(CFG_TRIGGER_TICKS, 16'(SWEEPS[s].trig));
            write_reg(CFG_TIMEOUT_TICKS, SWEEPS[s].timeout);
            write_reg(CFG_GROUP_SIZE, 16'(SWEEPS[s].grp));
            write_reg(CFG_DISTANCE_CEILING, SWEEPS[s].ceil);
            if (SWEEPS[s].long_hold)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < SWEEPS[s].items; n++)
            begin
                shape_echo(el, er);
                send_tick(el, er, 1'b0, NO_WORD);
                // shrink the group mid-count and move the ceiling
                if (SWEEPS[s].regroup && n == SWEEPS[s].items / 2)
                begin
                    wait_drained();
                    write_reg(CFG_GROUP_SIZE, 16'd2);
                    write_reg(CFG_DISTANCE_CEILING, 16'd300);
                end
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
